>>> src/sha_pkg.sv
// Shared types, round constants and mixing functions for the SHA-256 engine.
// Used by sha_sched, sha_round, sha256_hash_engine and sha_checker.
`timescale 1ns / 1ps
`default_nettype none

package sha_pkg;

	localparam int unsigned Words     = 16;
	localparam int unsigned HashWords = 8;

	localparam logic [31:0] PadMarker = 32'h8000_0000;

	typedef struct packed {
		logic [31:0] message_word;
		logic [2:0]  valid_bytes;
		logic        end_of_message;
	} sha_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  digest_index;
		logic        digest_last;
	} sha_digest_t;

	typedef struct packed {
		logic push;
		logic step;
	} sha_sched_ctl_t;

	typedef struct packed {
		logic load;
		logic step;
		logic accum;
		logic reinit;
	} sha_round_ctl_t;

	localparam logic [31:0] InitHash [HashWords] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

`default_nettype wire

>>> src/sha_sched.sv
// Message schedule: a 16-word shift line that collects block words and then
// expands the schedule one word per round. Depends on sha_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sha_sched
	import sha_pkg::*;
(
	input  wire logic           clk,
	input  wire sha_sched_ctl_t ctl,
	input  wire logic [31:0]    push_word,
	output logic      [31:0]    wt
);

	logic [31:0] win_q [Words];
	logic [31:0] next_w;
	logic [31:0] shift_in;

	// Entry 0 always holds the word for the current round.
	assign next_w   = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];
	assign shift_in = ctl.push ? push_word : next_w;
	assign wt       = win_q[0];

	always_ff @(posedge clk) begin
		if (ctl.push || ctl.step) begin
			for (int i = 0; i < Words - 1; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[Words - 1] <= shift_in;
		end
	end

endmodule

`default_nettype wire

>>> src/sha_round.sv
// Compression datapath: working variables a..h, one round per step, and the
// chaining hash registers with their accumulate and reinit. Depends on sha_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sha_round
	import sha_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire sha_round_ctl_t ctl,
	input  wire logic [31:0]    kt,
	input  wire logic [31:0]    wt,
	input  wire logic [2:0]     rd_idx,
	output logic      [31:0]    rd_word
);

	logic [31:0] hash_q [HashWords];
	logic [31:0] wv_q   [HashWords];
	logic [31:0] ch;
	logic [31:0] maj;
	logic [31:0] t1;
	logic [31:0] t2;

	assign ch  = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
	assign maj = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);
	assign t1  = wv_q[7] + big_sigma1(wv_q[4]) + ch + kt + wt;
	assign t2  = big_sigma0(wv_q[0]) + maj;

	assign rd_word = hash_q[rd_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HashWords; i++) begin
				hash_q[i] <= InitHash[i];
			end
		end else if (ctl.reinit) begin
			for (int i = 0; i < HashWords; i++) begin
				hash_q[i] <= InitHash[i];
			end
		end else if (ctl.accum) begin
			for (int i = 0; i < HashWords; i++) begin
				hash_q[i] <= hash_q[i] + wv_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			for (int i = 0; i < HashWords; i++) begin
				wv_q[i] <= hash_q[i];
			end
		end else if (ctl.step) begin
			wv_q[7] <= wv_q[6];
			wv_q[6] <= wv_q[5];
			wv_q[5] <= wv_q[4];
			wv_q[4] <= wv_q[3] + t1;
			wv_q[3] <= wv_q[2];
			wv_q[2] <= wv_q[1];
			wv_q[1] <= wv_q[0];
			wv_q[0] <= t1 + t2;
		end
	end

endmodule

`default_nettype wire

>>> src/sha256_hash_engine.sv
// SHA-256 engine top level. A word that does not complete a block leaves the engine idle.
// A word that completes a 16-word block holds the input through 64 rounds and the hash
// accumulation. A final word adds the padding words, one or two compressions, and eight
// digest transfers. Reset (arst_n low, asynchronous) restores the initial hash and
// clears the word and bit counters. Depends on sha_pkg, sha_sched and sha_round.
`timescale 1ns / 1ps
`default_nettype none

module sha256_hash_engine
	import sha_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire sha_item_t   item,
	output logic             digest_valid,
	input  wire logic        digest_stall,
	output sha_digest_t      digest
);

	// Sequencer states.
	localparam logic [2:0] StIdle     = 3'd0;
	localparam logic [2:0] StCompress = 3'd1;
	localparam logic [2:0] StFinish   = 3'd2;
	localparam logic [2:0] StPad      = 3'd3;
	localparam logic [2:0] StOut      = 3'd4;

	logic [2:0]  state_q;
	logic [3:0]  wib_q;       // words collected in the current block
	logic [5:0]  round_q;     // current compression round
	logic [63:0] bits_q;      // message length in bits, wraps
	logic        pad_q;       // padding of the final block is under way
	logic        marker_q;    // a full final word still needs the 0x80 marker word
	logic        hi_done_q;   // upper length word has been pushed
	logic        lo_done_q;   // lower length word has been pushed
	logic [2:0]  didx_q;      // digest word being offered

	logic           accept;
	logic           push;
	logic           block_full;
	logic           digest_xfer;
	logic [2:0]     nbytes;
	logic [31:0]    last_word;
	logic [31:0]    pad_word;
	logic [31:0]    push_word;
	logic [5:0]     bit_add;
	logic [31:0]    kt;
	logic [31:0]    wt;
	logic [31:0]    rd_word;
	sha_sched_ctl_t sched_ctl;
	sha_round_ctl_t round_ctl;

	// Input is taken only in the idle state; every other state owns the datapath.
	assign item_stall  = (state_q != StIdle);
	assign accept      = item_valid && (state_q == StIdle);
	assign digest_valid = (state_q == StOut);
	assign digest_xfer = digest_valid && !digest_stall;

	// A valid count above four counts as four; it matters only on the final word.
	assign nbytes = (item.valid_bytes > 3'd4) ? 3'd4 : item.valid_bytes;

	// Final word: bytes past the valid count are cleared and the marker byte
	// follows the last valid byte. A full final word is sent unchanged and the
	// marker goes into the next word.
	always_comb begin
		case (nbytes)
			3'd0:    last_word = PadMarker;
			3'd1:    last_word = {item.message_word[31:24], 8'h80, 16'h0000};
			3'd2:    last_word = {item.message_word[31:16], 8'h80, 8'h00};
			3'd3:    last_word = {item.message_word[31:8], 8'h80};
			default: last_word = item.message_word;
		endcase
	end

	// A non-final word always counts as 32 bits.
	assign bit_add = item.end_of_message ? {nbytes, 3'b000} : 6'd32;

	// Padding sequence: marker word if still owed, zero fill up to word 14,
	// then the 64-bit length, upper half first.
	always_comb begin
		if (marker_q) begin
			pad_word = PadMarker;
		end else if (hi_done_q) begin
			pad_word = bits_q[31:0];
		end else if (wib_q == 4'd14) begin
			pad_word = bits_q[63:32];
		end else begin
			pad_word = 32'h0000_0000;
		end
	end

	assign push       = accept || (state_q == StPad);
	assign push_word  = accept ? (item.end_of_message ? last_word : item.message_word)
	                           : pad_word;
	assign block_full = push && (wib_q == 4'd15);

	assign kt = RoundK[round_q];

	always_comb begin
		sched_ctl.push   = push;
		sched_ctl.step   = (state_q == StCompress);
		round_ctl.load   = block_full;
		round_ctl.step   = (state_q == StCompress);
		round_ctl.accum  = (state_q == StFinish);
		round_ctl.reinit = digest_xfer && (didx_q == 3'd7);
	end

	sha_sched u_sched (
		.clk       (clk),
		.ctl       (sched_ctl),
		.push_word (push_word),
		.wt        (wt)
	);

	sha_round u_round (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (round_ctl),
		.kt      (kt),
		.wt      (wt),
		.rd_idx  (didx_q),
		.rd_word (rd_word)
	);

	always_comb begin
		digest.digest_word  = rd_word;
		digest.digest_index = didx_q;
		digest.digest_last  = (didx_q == 3'd7);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= StIdle;
			wib_q     <= 4'd0;
			round_q   <= 6'd0;
			bits_q    <= 64'd0;
			pad_q     <= 1'b0;
			marker_q  <= 1'b0;
			hi_done_q <= 1'b0;
			lo_done_q <= 1'b0;
			didx_q    <= 3'd0;
		end else begin
			if (push) begin
				wib_q <= wib_q + 4'd1;
			end
			if (block_full) begin
				round_q <= 6'd0;
			end
			case (state_q)
				StIdle: begin
					if (accept) begin
						bits_q <= bits_q + {58'd0, bit_add};
						if (item.end_of_message) begin
							pad_q    <= 1'b1;
							marker_q <= (nbytes == 3'd4);
						end
						if (block_full) begin
							state_q <= StCompress;
						end else if (item.end_of_message) begin
							state_q <= StPad;
						end
					end
				end
				StPad: begin
					if (marker_q) begin
						marker_q <= 1'b0;
					end else if (hi_done_q) begin
						lo_done_q <= 1'b1;
					end else if (wib_q == 4'd14) begin
						hi_done_q <= 1'b1;
					end
					if (block_full) begin
						state_q <= StCompress;
					end
				end
				StCompress: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63) begin
						state_q <= StFinish;
					end
				end
				StFinish: begin
					if (lo_done_q) begin
						state_q <= StOut;
					end else if (pad_q) begin
						state_q <= StPad;
					end else begin
						state_q <= StIdle;
					end
				end
				StOut: begin
					if (digest_xfer) begin
						didx_q <= didx_q + 3'd1;
						if (didx_q == 3'd7) begin
							// Digest complete: start a fresh message.
							state_q   <= StIdle;
							wib_q     <= 4'd0;
							bits_q    <= 64'd0;
							pad_q     <= 1'b0;
							marker_q  <= 1'b0;
							hi_done_q <= 1'b0;
							lo_done_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= StIdle;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> src/sha_checker.sv
// Port-level checks for the SHA-256 engine, attached to the top level by bind.
// Depends on sha_pkg and on the port list of sha256_hash_engine.
`timescale 1ns / 1ps
`default_nettype none

module sha_checker
	import sha_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        item_valid,
	input wire logic        item_stall,
	input wire sha_item_t   item,
	input wire logic        digest_valid,
	input wire logic        digest_stall,
	input wire sha_digest_t digest
);

	// No message word can be taken while a digest is being delivered.
	a_no_input_during_digest: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> item_stall)
		else $error("input open while digest pending");

	// A final word always starts padding and compression work.
	a_busy_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && item.end_of_message) |=> item_stall)
		else $error("engine not busy after final word");

	// A stalled digest word holds.
	a_digest_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(digest_valid && digest_stall) |=> (digest_valid && $stable(digest)))
		else $error("stalled digest word changed");

	// Digest words follow each other in index order without gaps.
	a_digest_order: assert property (@(posedge clk) disable iff (!arst_n)
		(digest_valid && !digest_stall && !digest.digest_last) |=>
		(digest_valid && digest.digest_index == $past(digest.digest_index) + 3'd1))
		else $error("digest words out of order");

	// The last flag marks exactly the eighth word.
	a_digest_last: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> (digest.digest_last == (digest.digest_index == 3'd7)))
		else $error("digest last flag mismatch");

endmodule

bind sha256_hash_engine sha_checker u_sha_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.digest_valid (digest_valid),
	.digest_stall (digest_stall),
	.digest       (digest)
);

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for sha256_hash_engine: messages of random and directed content
// are hashed by a behavioral SHA-256 model and every digest transfer is checked against it.
// Depends on sha_pkg for the item and digest structs and on the engine RTL.

module tb_top;
	import sha_pkg::*;

	// Round constants and initial hash, kept here so that the bench does not lean on
	// the tables of the design it is checking.
	localparam bit [31:0] K_TABLE [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam bit [31:0] IV_TABLE [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam bit [31:0] PAD_BYTE = 32'h0000_0080;

	// The block is given as many cycles as this after the last digest word before the
	// run is judged, so that a stray extra transfer would still be seen.
	localparam int unsigned SETTLE_CYCLES = 200;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	sha_item_t   item = '0;
	logic        digest_valid;
	logic        digest_stall = 1'b0;
	sha_digest_t digest;

	sha256_hash_engine dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.digest_valid(digest_valid),
		.digest_stall(digest_stall),
		.digest      (digest)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case the engine hangs or stops handing out digest words.
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Behavioral hash state: running hash, the 16-word block being collected, how many
	// words of it are filled, and the message length in bits.
	logic [31:0] hash_state [8];
	logic [31:0] block_buf [16];
	int unsigned block_fill;
	logic [63:0] msg_bits;

	sha_item_t   pending_items [$];    // words still to be offered to the engine
	sha_digest_t expected_digest [$];  // digest words predicted but not yet seen

	int unsigned send_idle_pct = 36;
	int unsigned recv_idle_pct = 72;
	int unsigned mismatches = 0;
	logic        item_fire = 1'b0;     // the item on the bus was taken at the last rising edge

	function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic restart_hash();
		for (int i = 0; i < 8; i++) hash_state[i] = IV_TABLE[i];
		block_fill = 0;
		msg_bits = '0;
	endtask

	// One full compression over block_buf. The whole 64-entry schedule is expanded up
	// front, which is a different arrangement from the rolling window in hardware.
	task automatic compress_block();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
		for (int r = 0; r < 16; r++) w[r] = block_buf[r];
		for (int r = 16; r < 64; r++) begin
			s0 = ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3);
			s1 = ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10);
			w[r] = w[r-16] + s0 + w[r-7] + s1;
		end
		a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
		e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
		for (int r = 0; r < 64; r++) begin
			t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
				+ K_TABLE[r] + w[r];
			t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
		hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
	endtask

	task automatic absorb_word(input logic [31:0] word);
		block_buf[block_fill] = word;
		block_fill = (block_fill + 1) % 16;
		if (block_fill == 0) compress_block();
	endtask

	// Advance the hash model by one accepted word. A final word closes the message:
	// the bytes past the valid count are cleared, the 0x80 marker, the zero fill and
	// the 64-bit length follow, and the eight digest words are queued for checking.
	task automatic hash_item(input sha_item_t it);
		int unsigned nbytes;
		logic [31:0] keep;
		logic [63:0] length;
		sha_digest_t word_out;
		if (!it.end_of_message) begin
			// Valid count means nothing on a word that is not the last one.
			msg_bits += 64'd32;
			absorb_word(it.message_word);
			return;
		end
		nbytes = (it.valid_bytes > 3'd4) ? 4 : it.valid_bytes;
		msg_bits += 64'(8 * nbytes);
		length = msg_bits;
		if (nbytes < 4) begin
			keep = (nbytes == 0) ? 32'h0 : ~(32'hFFFF_FFFF >> (8 * nbytes));
			absorb_word((it.message_word & keep) | (PAD_BYTE << (24 - 8 * nbytes)));
		end else begin
			absorb_word(it.message_word);
			absorb_word(PAD_BYTE << 24);
		end
		while (block_fill != 14) absorb_word(32'h0);
		absorb_word(length[63:32]);
		absorb_word(length[31:0]);
		for (int i = 0; i < 8; i++) begin
			word_out.digest_word  = hash_state[i];
			word_out.digest_index = 3'(i);
			word_out.digest_last  = (i == 7);
			expected_digest.push_back(word_out);
		end
		restart_hash();
	endtask

	task automatic queue_word(input logic [31:0] word, input logic [2:0] nbytes,
			input logic last);
		sha_item_t it;
		it.message_word   = word;
		it.valid_bytes    = nbytes;
		it.end_of_message = last;
		pending_items.push_back(it);
	endtask

	// Whole random messages until at least n_items words are queued. Lengths favor
	// short messages and those near a block boundary, where the padding either fits
	// or spills into an extra block.
	task automatic queue_random_messages(input int unsigned n_items);
		int unsigned queued;
		int unsigned len;
		int unsigned pick;
		queued = 0;
		while (queued < n_items) begin
			pick = $urandom_range(9);
			if (pick < 3) len = $urandom_range(4, 1);
			else if (pick < 7) len = $urandom_range(18, 12);
			else len = $urandom_range(40, 1);
			for (int i = 0; i < len - 1; i++)
				queue_word($urandom, ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'd4,
					1'b0);
			queue_word($urandom, 3'($urandom_range(7)), 1'b1);
			queued += len;
		end
	endtask

	// Hold until every queued word has been taken and every predicted digest word seen.
	task automatic drain();
		while (pending_items.size() != 0 || item_valid || expected_digest.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// Sender side. A new word goes on the bus only once the previous one has been
	// transferred; the idle draw decides whether a free slot is used this cycle.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!item_valid || item_fire) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					item <= pending_items.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
			digest_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Both channels are observed at the rising edge. An accepted word steps the model
	// before the digest channel is looked at, although a word can never produce a digest
	// word in the very cycle it is transferred.
	always @(posedge clk) begin : observe
		sha_digest_t want;
		if (arst_n) begin
			item_fire <= item_valid && !item_stall;
			if (item_valid && !item_stall) hash_item(item);
			if (digest_valid && !digest_stall) begin
				if (expected_digest.size() == 0) begin
					$error("unexpected digest transfer: word %h index %0d last %0b",
						digest.digest_word, digest.digest_index, digest.digest_last);
					mismatches++;
				end else begin
					want = expected_digest.pop_front();
					if (digest.digest_word !== want.digest_word) begin
						$error("digest_word: expected %h, got %h",
							want.digest_word, digest.digest_word);
						mismatches++;
					end
					if (digest.digest_index !== want.digest_index) begin
						$error("digest_index: expected %0d, got %0d",
							want.digest_index, digest.digest_index);
						mismatches++;
					end
					if (digest.digest_last !== want.digest_last) begin
						$error("digest_last: expected %0b, got %0b",
							want.digest_last, digest.digest_last);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin
		restart_hash();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed messages, sent under the first idling mix.
		// Empty message: the final word carries no bytes, only the padding.
		queue_word(32'h0000_0000, 3'd0, 1'b1);
		// Three bytes with a stray fourth byte that must be cleared before the marker.
		queue_word(32'h6162_63FF, 3'd3, 1'b1);
		// Full final word, all ones, and a valid count beyond four on the next two.
		queue_word(32'hFFFF_FFFF, 3'd4, 1'b1);
		queue_word(32'hFFFF_FFFF, 3'd7, 1'b1);
		queue_word(32'h0000_0000, 3'd6, 1'b1);
		// A short count on a word that is not last counts as four bytes.
		queue_word(32'hA5A5_A5A5, 3'd1, 1'b0);
		queue_word(32'h1234_5678, 3'd2, 1'b1);
		// Fourteen full words: the marker lands in slot 14, so the length needs a
		// second block.
		for (int i = 0; i < 13; i++) queue_word($urandom, 3'd4, 1'b0);
		queue_word($urandom, 3'd4, 1'b1);
		drain();

		queue_random_messages(80);
		drain();

		send_idle_pct = 72;
		recv_idle_pct = 36;
		queue_random_messages(80);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random_messages(80);
		drain();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_digest.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

>>> sha256_hash_engine.f
src/sha_pkg.sv
src/sha_sched.sv
src/sha_round.sv
src/sha256_hash_engine.sv
src/sha_checker.sv
sim/tb_top.sv
